// File: rtl/rolling_hash_trigger_detector_assert.svh
// assertion macros for the rolling hash trigger detector
`ifndef ROLLING_HASH_TRIGGER_DETECTOR_ASSERT_SVH
`define ROLLING_HASH_TRIGGER_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RHTD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhtd assertion failed");

// next-cycle implication, disabled in reset
`define RHTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhtd assertion failed");

`endif

// File: rtl/rhtd_pkg.sv
// types, constants and modular helpers for the rolling hash trigger detector
package rhtd_pkg;

  localparam logic [30:0] KR_PRIME = 31'd1999999973;

  localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [1:0] CFG_MODULUS       = 2'd1;
  localparam logic [1:0] CFG_INVALID_LIMIT = 2'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [30:0] hash_value;
    logic        boundary;
    logic        window_full;
    logic        rejected;
  } out_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       restart;
    logic       rejected;
  } work_t;

  typedef enum logic [3:0] {
    B_WEIGHT,
    B_IDLE,
    B_MUL,
    B_SUB,
    B_SHIFT,
    B_ADD,
    B_CHK,
    B_MOD,
    B_DONE
  } back_state_t;

  // sum of two residues, both below the prime
  function automatic logic [30:0] mod_add(input logic [30:0] a, input logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, KR_PRIME}) s = s - {1'b0, KR_PRIME};
    return s[30:0];
  endfunction

endpackage

// File: rtl/rhtd_fifo.sv
// two-entry queue of packed items
module rhtd_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/rhtd_front.sv
// front end: uppercases and classifies symbols, queues them for the engine
module rhtd_front
  import rhtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  in_item_t   item,
  output logic       full,
  input  logic [7:0] invalid_limit,
  input  logic       q_pop,
  output work_t      q_item,
  output logic       q_empty
);

  work_t      w;
  logic [7:0] c;

  always_comb begin
    c = item.symbol;
    if (c >= 8'd97 && c <= 8'd122) c = c - 8'd32;
    w.symbol   = c;
    w.restart  = item.restart;
    w.rejected = (c <= invalid_limit);
  end

  rhtd_fifo #(.W($bits(work_t))) u_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (w),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

endmodule

// File: rtl/rhtd_back.sv
// back end: window store, serial modular hash update and boundary check
module rhtd_back
  import rhtd_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_ws_we,
  input  logic [6:0]  cfg_ws_data,
  input  logic [31:0] modulus,
  input  work_t       q_item,
  input  logic        q_empty,
  output logic        q_pop,
  output out_item_t   res,
  output logic        out_push,
  input  logic        out_full,
  output logic        idle
);

  localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int RESET_WS = (10 > WINDOW_MAX) ? WINDOW_MAX : 10;

  back_state_t state, state_next;

  logic [7:0]    mem [WINDOW_MAX];
  logic [7:0]    rd_data;
  logic [CW-1:0] wsize;
  logic [CW-1:0] fill;
  logic [CW-1:0] wcnt;
  logic [SW-1:0] slot;
  logic [30:0]   hash;
  logic [30:0]   weight;
  logic [30:0]   acc;
  logic [31:0]   rem;
  logic [32:0]   rem_sh;
  logic [4:0]    bitcnt;
  logic          oldzero;
  logic          bnd_en;
  work_t         cur;
  logic [7:0]    old_byte;
  logic [CW-1:0] ws_sat;
  logic [CW-1:0] slot_inc;
  logic          is_full;

  always_comb begin
    if (cfg_ws_data < 7'd4) ws_sat = CW'(4);
    else if (32'(cfg_ws_data) > WINDOW_MAX) ws_sat = CW'(WINDOW_MAX);
    else ws_sat = CW'(cfg_ws_data);
  end

  assign old_byte = oldzero ? 8'd0 : rd_data;
  assign slot_inc = CW'(slot) + CW'(1);
  assign is_full  = (fill >= wsize);
  assign rem_sh   = {rem, hash[5'd30 - bitcnt]};

  always_comb begin
    state_next = state;
    case (state)
      B_WEIGHT: if (wcnt == '0) state_next = B_IDLE;
      B_IDLE:   if (!q_empty) state_next = q_item.rejected ? B_DONE : B_MUL;
      B_MUL:    if (bitcnt[2:0] == 3'd7) state_next = B_SUB;
      B_SUB:    state_next = B_SHIFT;
      B_SHIFT:  if (bitcnt[2:0] == 3'd7) state_next = B_ADD;
      B_ADD:    state_next = B_CHK;
      B_CHK:    state_next = (is_full && modulus != 32'd0) ? B_MOD : B_DONE;
      B_MOD:    if (bitcnt == 5'd30) state_next = B_DONE;
      B_DONE:   if (!out_full) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
    if (cfg_ws_we) state_next = B_WEIGHT;
  end

  always_comb begin
    q_pop           = (state == B_IDLE) && !q_empty;
    out_push        = (state == B_DONE) && !out_full;
    idle            = (state == B_IDLE);
    res.hash_value  = hash;
    res.boundary    = bnd_en && (rem == 32'd0);
    res.window_full = is_full;
    res.rejected    = cur.rejected;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          cur     <= q_item;
          rd_data <= mem[q_item.restart ? '0 : slot];
          oldzero <= q_item.restart || (fill < wsize);
          acc     <= '0;
          bitcnt  <= '0;
          bnd_en  <= 1'b0;
        end
      end
      B_MUL: begin
        acc    <= mod_add(mod_add(acc, acc),
                          old_byte[3'd7 - bitcnt[2:0]] ? weight : 31'd0);
        bitcnt <= bitcnt + 5'd1;
        if (bitcnt[2:0] == 3'd7) bitcnt <= '0;
      end
      B_SUB: begin
        acc <= mod_add(hash, KR_PRIME - acc);
      end
      B_SHIFT: begin
        acc    <= mod_add(acc, acc);
        bitcnt <= bitcnt + 5'd1;
      end
      B_ADD: begin
        mem[slot] <= cur.symbol;
      end
      B_CHK: begin
        rem    <= '0;
        bitcnt <= '0;
        bnd_en <= is_full && (modulus != 32'd0);
      end
      B_MOD: begin
        rem    <= (rem_sh >= {1'b0, modulus}) ? 32'(rem_sh - {1'b0, modulus})
                                                : rem_sh[31:0];
        bitcnt <= bitcnt + 5'd1;
      end
      default: begin
      end
    endcase

    if (rst) begin
      state  <= B_WEIGHT;
      wsize  <= CW'(RESET_WS);
      wcnt   <= CW'(RESET_WS - 1);
      acc    <= 31'd1;
      bitcnt <= '0;
      hash   <= '0;
      slot   <= '0;
      fill   <= '0;
      weight <= '0;
    end else begin
      state <= state_next;
      if (cfg_ws_we) begin
        wsize  <= ws_sat;
        wcnt   <= ws_sat - CW'(1);
        acc    <= 31'd1;
        bitcnt <= '0;
        hash   <= '0;
        slot   <= '0;
        fill   <= '0;
      end else begin
        case (state)
          B_WEIGHT: begin
            if (wcnt == '0) begin
              weight <= acc;
            end else begin
              acc    <= mod_add(acc, acc);
              bitcnt <= bitcnt + 5'd1;
              if (bitcnt[2:0] == 3'd7) wcnt <= wcnt - CW'(1);
            end
          end
          B_IDLE: begin
            if (!q_empty && !q_item.rejected && q_item.restart) begin
              hash <= '0;
              slot <= '0;
              fill <= '0;
            end
          end
          B_ADD: begin
            hash <= mod_add(acc, {23'd0, cur.symbol});
            slot <= (slot_inc >= wsize) ? '0 : slot + SW'(1);
            if (fill < wsize) fill <= fill + CW'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/rolling_hash_trigger_detector.sv
// top level of the rolling hash trigger detector
//
// Input channel: push/full carries one symbol and a restart flag per transfer.
// Result channel: empty/pop; one result per input symbol, in order, carrying
// the running Karp-Rabin hash (base 256, mod 1999999973), window_full,
// boundary and rejected.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// the window size, 1 the boundary modulus, 2 the invalid symbol limit.
// cfg_ready is high only while the engine is idle and no symbol is queued.
// A front stage uppercases and classifies symbols into a two-entry queue; a
// back engine works on one symbol at a time with a shared modular doubler.
// A symbol steps through MUL (old byte times weight), SUB, SHIFT (times
// 256), ADD, CHK, then, with a full window and a nonzero modulus, the
// boundary remainder (31 steps), and DONE; a rejected symbol goes straight
// to DONE. The engine takes no new symbol until the last result is pushed.
// After reset, and after each window size write, the engine computes the
// leading weight before it takes a symbol; symbols may still queue up in
// front meanwhile.
// A stalled result side fills the two-entry result queue, then the engine
// waits, then the input queue fills and full rises.
module rolling_hash_trigger_detector
  import rhtd_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  in_item_t    item,
  output logic        full,
  input  logic        pop,
  output out_item_t   result,
  output logic        empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] modulus;
  logic [7:0]  invalid_limit;
  logic        cfg_fire;
  logic        q_pop;
  logic        q_empty;
  work_t       q_item;
  out_item_t   res;
  logic        out_push;
  logic        out_full;
  logic        idle;

  assign cfg_ready = idle && q_empty;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= 32'd100;
      invalid_limit <= 8'd2;
    end else if (cfg_fire) begin
      if (cfg_index == CFG_MODULUS) modulus <= cfg_data;
      if (cfg_index == CFG_INVALID_LIMIT) invalid_limit <= cfg_data[7:0];
    end
  end

  rhtd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .item          (item),
    .full          (full),
    .invalid_limit (invalid_limit),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .q_empty       (q_empty)
  );

  rhtd_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_ws_we   (cfg_fire && cfg_index == CFG_WINDOW_SIZE),
    .cfg_ws_data (cfg_data[6:0]),
    .modulus     (modulus),
    .q_item      (q_item),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .res         (res),
    .out_push    (out_push),
    .out_full    (out_full),
    .idle        (idle)
  );

  rhtd_fifo #(.W($bits(out_item_t))) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

// File: rtl/rhtd_checker.sv
// port-level checker for the rolling hash trigger detector, with its bind
`include "rolling_hash_trigger_detector_assert.svh"

module rhtd_checker
  import rhtd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      pop,
  input logic      empty,
  input out_item_t result
);

  `RHTD_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), empty)
  `RHTD_ASSERT_NOW(a_reject_no_bnd, clk, rst, !empty && result.rejected, !result.boundary)
  `RHTD_ASSERT_NOW(a_bnd_needs_full, clk, rst, !empty && result.boundary, result.window_full)
  `RHTD_ASSERT_NEXT(a_stall_hold, clk, rst, !empty && !pop, !empty && $stable(result))

endmodule

bind rolling_hash_trigger_detector rhtd_checker u_rhtd_checker (
  .clk    (clk),
  .rst    (rst),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);

// File: tb/rolling_hash_trigger_detector_tb.sv
// self-checking testbench for the rolling hash trigger detector
`timescale 1ns / 100ps

module rolling_hash_trigger_detector_tb
  import rhtd_pkg::*;
;

  localparam int              WIN_MAX    = 64;
  localparam longint unsigned PRIME      = 64'd1999999973;
  localparam logic [1:0]      CFG_UNUSED = 2'd3;
  localparam int              STALL_MAX  = 3000;

  typedef struct {
    logic [7:0]  symbol;
    logic        restart;
    bit          known;
    out_item_t   exp;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        push;
  in_item_t    item;
  logic        full;
  logic        pop;
  out_item_t   result;
  logic        empty;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // predictor state
  logic [7:0]      pred_store [WIN_MAX];
  longint unsigned kr_hash;
  int unsigned     kr_slot;
  int unsigned     kr_fill;
  longint unsigned kr_weight;
  int unsigned     win_len;
  logic [31:0]     divisor;
  logic [7:0]      rej_limit;

  out_item_t exp_results[$];
  int        errors;
  int        n_items;
  int        n_results;
  int        n_boundary;
  int        n_rejected;
  int        n_cfg;
  int        idle_cycles;
  bit        no_idle;

  dir_row_t dir_rows [20];

  rolling_hash_trigger_detector DUT (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full),
    .pop(pop), .result(result), .empty(empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_window();
    foreach (pred_store[i]) pred_store[i] = 8'd0;
    kr_hash = 0;
    kr_slot = 0;
    kr_fill = 0;
  endfunction

  function automatic void set_window(logic [6:0] v);
    longint unsigned p;
    int unsigned     w;
    w = v;
    if (w < 4) w = 4;
    if (w > WIN_MAX) w = WIN_MAX;
    win_len = w;
    clear_window();
    p = 1;
    for (int i = 1; i < w; i++) p = (p * 256) % PRIME;
    kr_weight = p;
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      CFG_WINDOW_SIZE:   set_window(data[6:0]);
      CFG_MODULUS:       divisor = data;
      CFG_INVALID_LIMIT: rej_limit = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic out_item_t hash_step(in_item_t in);
    out_item_t       r;
    logic [7:0]      c;
    longint unsigned h;
    bit              rej;
    bit              is_full;
    c = in.symbol;
    if (c >= 8'h61 && c <= 8'h7a) c = c - 8'd32;
    rej = (c <= rej_limit);
    if (!rej) begin
      if (in.restart) clear_window();
      h = kr_hash + PRIME - (longint'(pred_store[kr_slot]) * kr_weight) % PRIME;
      h = (256 * h + c) % PRIME;
      kr_hash = h;
      pred_store[kr_slot] = c;
      kr_slot = kr_slot + 1;
      if (kr_slot >= win_len) kr_slot = 0;
      if (kr_fill < win_len) kr_fill++;
    end
    is_full = (kr_fill >= win_len);
    r.hash_value  = kr_hash[30:0];
    r.window_full = is_full;
    r.rejected    = rej;
    r.boundary    = !rej && is_full && divisor != 0 && (kr_hash % divisor) == 0;
    return r;
  endfunction

  task automatic send_item(in_item_t in, bit known, out_item_t typed);
    int        gap;
    out_item_t pr;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= in;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    pr = hash_step(in);
    exp_results.insert(exp_results.size(), known ? typed : pr);
    n_items++;
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    apply_cfg(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (exp_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    in_item_t in;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85 && rej_limit != 8'hff)
        in.symbol = 8'($urandom_range(255, rej_limit + 1));
      else
        in.symbol = 8'($urandom_range(0, 255));
      in.restart = ($urandom_range(0, 99) < 3);
      send_item(in, 1'b0, '0);
    end
    no_idle = 1'b0;
  endtask

  // result side
  initial begin
    int        stall;
    out_item_t e;
    pop <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      forever begin
        @(posedge clk);
        if (!empty) break;
      end
      n_results++;
      if (exp_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %p", $time, result);
        errors++;
      end else begin
        e = exp_results.pop_front();
        if (result.hash_value !== e.hash_value) begin
          $display("%0t: hash_value expected %0d actual %0d", $time, e.hash_value,
                   result.hash_value);
          errors++;
        end
        if (result.boundary !== e.boundary) begin
          $display("%0t: boundary expected %0b actual %0b", $time, e.boundary,
                   result.boundary);
          errors++;
        end
        if (result.window_full !== e.window_full) begin
          $display("%0t: window_full expected %0b actual %0b", $time, e.window_full,
                   result.window_full);
          errors++;
        end
        if (result.rejected !== e.rejected) begin
          $display("%0t: rejected expected %0b actual %0b", $time, e.rejected,
                   result.rejected);
          errors++;
        end
      end
      if (result.boundary === 1'b1) n_boundary++;
      if (result.rejected === 1'b1) n_rejected++;
      @(negedge clk);
    end
  end

  // watchdog on transfers of any kind
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("%0t: timeout, %0d results outstanding", $time, exp_results.size());
      $display("** rolling_hash_trigger_detector: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_item_t    in;
    logic [6:0]  wins [6];
    logic [31:0] mods [6];
    logic [7:0]  lims [6];
    wins = '{7'd5, 7'd0, 7'd127, 7'd17, 7'd33, 7'd8};
    mods = '{32'd2, 32'd0, 32'd3, 32'd7, 32'd10, 32'd1};
    lims = '{8'd32, 8'd64, 8'd1, 8'd90, 8'd10, 8'd47};
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_boundary = 0;
    n_rejected = 0;
    n_cfg = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    divisor = 32'd100;
    rej_limit = 8'd2;
    set_window(7'd10);

    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, '{31'd0,   1'b0, 1'b0, 1'b1}},
      '{8'h02, 1'b1, 1'b1, '{31'd0,   1'b0, 1'b0, 1'b1}},
      '{8'h03, 1'b0, 1'b1, '{31'd3,   1'b0, 1'b0, 1'b0}},
      '{8'h61, 1'b0, 1'b1, '{31'd833, 1'b0, 1'b0, 1'b0}},
      '{8'h7a, 1'b0, 1'b0, '0},
      '{8'h7b, 1'b0, 1'b0, '0},
      '{8'h60, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h5a, 1'b0, 1'b0, '0},
      '{8'h41, 1'b0, 1'b0, '0},
      '{8'h7f, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h30, 1'b0, 1'b0, '0},
      '{8'haa, 1'b0, 1'b0, '0},
      '{8'h55, 1'b1, 1'b0, '0},
      '{8'h41, 1'b1, 1'b1, '{31'd65,    1'b0, 1'b0, 1'b0}},
      '{8'h42, 1'b0, 1'b1, '{31'd16706, 1'b0, 1'b0, 1'b0}},
      '{8'hfe, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      in.symbol  = dir_rows[i].symbol;
      in.restart = dir_rows[i].restart;
      send_item(in, dir_rows[i].known, dir_rows[i].exp);
    end
    drain();

    // smallest window, every full window a boundary, only zero symbols rejected
    write_cfg(CFG_WINDOW_SIZE, 32'd4);
    write_cfg(CFG_MODULUS, 32'd1);
    write_cfg(CFG_INVALID_LIMIT, 32'd0);
    write_cfg(CFG_UNUSED, 32'hffff_ffff);
    random_phase(250);
    drain();

    // largest window and divisor
    write_cfg(CFG_WINDOW_SIZE, 32'd64);
    write_cfg(CFG_MODULUS, 32'hffff_ffff);
    write_cfg(CFG_INVALID_LIMIT, 32'd2);
    random_phase(200);
    drain();

    // everything rejected
    write_cfg(CFG_INVALID_LIMIT, 32'hff);
    random_phase(20);
    drain();

    // out-of-range window size, with the upper data bits set
    write_cfg(CFG_WINDOW_SIZE, 32'hffff_ffc9);
    write_cfg(CFG_INVALID_LIMIT, 32'd2);
    write_cfg(CFG_MODULUS, 32'd2);
    random_phase(100);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_WINDOW_SIZE, {25'd0, wins[p]});
      write_cfg(CFG_MODULUS, mods[p]);
      write_cfg(CFG_INVALID_LIMIT, {24'd0, lims[p]});
      random_phase(230);
      drain();
    end

    $display("covered %0d symbols, %0d results, %0d boundaries, %0d rejected",
             n_items, n_results, n_boundary, n_rejected);
    $display("%0d register writes across window sizes 4 to 64", n_cfg);
    if (errors == 0 && exp_results.size() == 0) begin
      $display("** rolling_hash_trigger_detector: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, exp_results.size());
      $display("** rolling_hash_trigger_detector: FAILED **");
    end
    $finish;
  end

endmodule
